>>> src/hsfc_pkg.sv
// shared types, constants and reset values for the humidity sensor frame checker
package hsfc_pkg;

  // crc-8 over each 16-bit word, msb first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // conversion constants
  localparam int TEMP_SPAN  = 17500;
  localparam int TEMP_OFS   = 4500;
  localparam int HUMID_SPAN = 12500;
  localparam int HUMID_OFS  = 600;
  localparam int HUMID_MAX  = 10000;

  // field widths
  localparam int TEMP_W   = 15;
  localparam int HUMID_W  = 14;
  localparam int STREAK_W = 8;
  localparam int COUNT_W  = 32;

  localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID_TRIGGER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK_NEEDED = 1'd1;
  localparam logic [HUMID_W-1:0]  HUMID_TRIGGER_RST = 14'd9800;
  localparam logic [STREAK_W-1:0] STREAK_NEEDED_RST = 8'd3;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // item class decided by the front
  typedef enum logic [1:0] {
    CLS_FRAME = 2'd0,
    CLS_BAD   = 2'd1,
    CLS_HEAT  = 2'd2
  } cls_t;

  // queued job
  typedef struct packed {
    cls_t        cls;
    logic [15:0] traw;
    logic [15:0] hraw;
    logic        wok;
  } job_t;

endpackage

>>> src/hsfc_in_if.sv
// input channel interface: one sensor frame or heater service request
interface hsfc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] temp_high_byte;
  logic [7:0] temp_low_byte;
  logic [7:0] temp_check_byte;
  logic [7:0] humid_high_byte;
  logic [7:0] humid_low_byte;
  logic [7:0] humid_check_byte;
  logic       heater_write_ok;

  modport source (
    output valid, operation, temp_high_byte, temp_low_byte, temp_check_byte,
           humid_high_byte, humid_low_byte, humid_check_byte, heater_write_ok,
    input  ready
  );

  modport sink (
    input  valid, operation, temp_high_byte, temp_low_byte, temp_check_byte,
           humid_high_byte, humid_low_byte, humid_check_byte, heater_write_ok,
    output ready
  );
endinterface

>>> src/hsfc_out_if.sv
// result channel interface: one result per accepted item
interface hsfc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               status;
  logic                               reading_valid;
  logic signed [hsfc_pkg::TEMP_W-1:0] temperature_c100;
  logic [hsfc_pkg::HUMID_W-1:0]       humidity_p100;
  logic                               heater_fired;
  logic [hsfc_pkg::STREAK_W-1:0]      streak_now;
  logic [hsfc_pkg::COUNT_W-1:0]       crc_failure_total;

  modport source (
    output valid, status, reading_valid, temperature_c100, humidity_p100,
           heater_fired, streak_now, crc_failure_total,
    input  ready
  );

  modport sink (
    input  valid, status, reading_valid, temperature_c100, humidity_p100,
           heater_fired, streak_now, crc_failure_total,
    output ready
  );
endinterface

>>> src/humidity_sensor_frame_checker.sv
// top level of the humidity sensor frame checker
//
// in_ch takes one transaction per item: a measurement frame (two raw words, each
// with its crc-8 byte) or a heater service request. out_ch returns exactly one
// result transaction per item, in order. cfg_we/cfg_index/cfg_data write the
// humidity trigger (index 0) and the required streak (index 1);
// write them only while no item is in flight.
//
// a result reaches out_ch through the crc stage, the queue, the multiply stage,
// the divide/clamp stage and the result register, in that order.
// throughput: one item per cycle while out_ch does not stall; the streak and
// failure-count update in the result stage is the loop that sets this figure.
//
// reset clears the pipeline, the queue, the streak and the failure count, and
// loads the configuration reset values. when out_ch stalls the result register
// holds, the stages behind it fill, then the job queue, then in_ch.ready drops.
module humidity_sensor_frame_checker #(
  parameter int QUEUE_DEPTH = hsfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hsfc_in_if.sink                         in_ch,
  hsfc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsfc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           push_vld;
  logic           push_rdy;
  hsfc_pkg::job_t push_job;
  logic           pop_vld;
  logic           pop_rdy;
  hsfc_pkg::job_t pop_job;

  // crc check and classification
  hsfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push_vld (push_vld),
    .push_rdy (push_rdy),
    .push_job (push_job)
  );

  // decoupling queue
  hsfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_rdy (push_rdy),
    .push_job (push_job),
    .pop_vld  (pop_vld),
    .pop_rdy  (pop_rdy),
    .pop_job  (pop_job)
  );

  // conversion, state and results
  hsfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_vld   (pop_vld),
    .pop_rdy   (pop_rdy),
    .pop_job   (pop_job),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );

endmodule

>>> src/hsfc_front.sv
// front end: accepts items, checks both crc-8 bytes and classifies the item
module hsfc_front (
  input  logic           clk,
  input  logic           rst_n,
  hsfc_in_if.sink        in_ch,
  output logic           push_vld,
  input  logic           push_rdy,
  output hsfc_pkg::job_t push_job
);

  // one crc-8 byte step, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ hsfc_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  logic        a_vld_r;
  logic        a_op_r;
  logic [15:0] a_traw_r;
  logic [15:0] a_hraw_r;
  logic [7:0]  a_tchk_r;
  logic [7:0]  a_hchk_r;
  logic [7:0]  a_tcrc_r;
  logic [7:0]  a_hcrc_r;
  logic        a_wok_r;
  logic        in_rdy;
  logic [7:0]  tcrc;
  logic [7:0]  hcrc;

  // stage register frees up when its content moves into the queue
  assign in_rdy      = !a_vld_r || push_rdy;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_rdy) begin
      a_vld_r <= in_ch.valid;
    end
  end

  // capture transaction and crc over the high bytes
  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      a_op_r   <= in_ch.operation;
      a_traw_r <= {in_ch.temp_high_byte, in_ch.temp_low_byte};
      a_hraw_r <= {in_ch.humid_high_byte, in_ch.humid_low_byte};
      a_tchk_r <= in_ch.temp_check_byte;
      a_hchk_r <= in_ch.humid_check_byte;
      a_tcrc_r <= crc8_byte(hsfc_pkg::CRC_INIT, in_ch.temp_high_byte);
      a_hcrc_r <= crc8_byte(hsfc_pkg::CRC_INIT, in_ch.humid_high_byte);
      a_wok_r  <= in_ch.heater_write_ok;
    end
  end

  // finish crc over the low bytes and classify
  assign tcrc = crc8_byte(a_tcrc_r, a_traw_r[7:0]);
  assign hcrc = crc8_byte(a_hcrc_r, a_hraw_r[7:0]);

  always_comb begin
    push_job.traw = a_traw_r;
    push_job.hraw = a_hraw_r;
    push_job.wok  = a_wok_r;
    priority if (a_op_r) begin
      push_job.cls = hsfc_pkg::CLS_HEAT;
    end else if (tcrc != a_tchk_r || hcrc != a_hchk_r) begin
      push_job.cls = hsfc_pkg::CLS_BAD;
    end else begin
      push_job.cls = hsfc_pkg::CLS_FRAME;
    end
  end

  assign push_vld = a_vld_r;

endmodule

>>> src/hsfc_queue.sv
// short job queue between the front and the back
module hsfc_queue #(
  parameter int DEPTH = hsfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_vld,
  output logic           push_rdy,
  input  hsfc_pkg::job_t push_job,
  output logic           pop_vld,
  input  logic           pop_rdy,
  output hsfc_pkg::job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  hsfc_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_rdy = (cnt_r != CNT_W'(DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_job  = mem_r[rptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

>>> src/hsfc_back.sv
// back end: unit conversion, streak and failure counting, heater service, result register
module hsfc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pop_vld,
  output logic                             pop_rdy,
  input  hsfc_pkg::job_t                   pop_job,
  input  logic                             cfg_we,
  input  logic [hsfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsfc_pkg::CFG_DATA_W-1:0]  cfg_data,
  hsfc_out_if.source                       out_ch
);

  localparam int TW = hsfc_pkg::TEMP_W;
  localparam int HW = hsfc_pkg::HUMID_W;
  localparam int SW = hsfc_pkg::STREAK_W;
  localparam int CW = hsfc_pkg::COUNT_W;

  // multiply stage
  logic           m_vld_r;
  hsfc_pkg::cls_t m_cls_r;
  logic [30:0]    m_tprod_r;
  logic [29:0]    m_hprod_r;
  logic           m_wok_r;
  logic           m_adv;

  // divide and clamp stage
  logic           d_vld_r;
  hsfc_pkg::cls_t d_cls_r;
  logic [TW-1:0]  d_temp_r;
  logic [HW-1:0]  d_humid_r;
  logic           d_wok_r;
  logic           d_adv;

  // state, configuration and result registers
  logic [SW-1:0]  streak_r, streak_nxt;
  logic [CW-1:0]  fail_cnt_r, fail_cnt_nxt;
  logic [HW-1:0]  humid_trig_r;
  logic [SW-1:0]  streak_need_r;
  logic           out_vld_r;
  logic           status_r, status_nxt;
  logic           rvalid_r, rvalid_nxt;
  logic [TW-1:0]  temp_r, temp_nxt;
  logic [HW-1:0]  humid_r, humid_nxt;
  logic           fired_r, fired_nxt;

  // conversion datapath
  logic [31:0]    tsum;
  logic [15:0]    tq;
  logic [30:0]    hsum;
  logic [14:0]    hq;
  logic [14:0]    hdiff;
  logic [TW-1:0]  temp_conv;
  logic [HW-1:0]  humid_conv;

  // elastic handshake between stages
  assign d_adv   = d_vld_r && (!out_vld_r || out_ch.ready);
  assign m_adv   = m_vld_r && (!d_vld_r || d_adv);
  assign pop_rdy = !m_vld_r || m_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (pop_rdy) begin
        m_vld_r <= pop_vld;
      end
      if (!d_vld_r || d_adv) begin
        d_vld_r <= m_vld_r;
      end
      if (!out_vld_r || out_ch.ready) begin
        out_vld_r <= d_vld_r;
      end
    end
  end

  // raw word times span
  always_ff @(posedge clk) begin
    if (pop_rdy && pop_vld) begin
      m_cls_r   <= pop_job.cls;
      m_tprod_r <= 31'(pop_job.traw) * 31'(hsfc_pkg::TEMP_SPAN);
      m_hprod_r <= 30'(pop_job.hraw) * 30'(hsfc_pkg::HUMID_SPAN);
      m_wok_r   <= pop_job.wok;
    end
  end

  // divide by 65535 as (p + (p >> 16) + 1) >> 16, exact for p below 2^32
  always_comb begin
    tsum      = 32'(m_tprod_r) + 32'(m_tprod_r >> 16) + 32'd1;
    tq        = tsum[31:16];
    temp_conv = TW'(tq - 16'(hsfc_pkg::TEMP_OFS));
    hsum      = 31'(m_hprod_r) + 31'(m_hprod_r >> 16) + 31'd1;
    hq        = hsum[30:16];
    hdiff     = hq - 15'(hsfc_pkg::HUMID_OFS);
    if (hq < 15'(hsfc_pkg::HUMID_OFS)) begin
      humid_conv = '0;
    end else if (hdiff > 15'(hsfc_pkg::HUMID_MAX)) begin
      humid_conv = HW'(hsfc_pkg::HUMID_MAX);
    end else begin
      humid_conv = hdiff[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) begin
      d_cls_r   <= m_cls_r;
      d_temp_r  <= temp_conv;
      d_humid_r <= humid_conv;
      d_wok_r   <= m_wok_r;
    end
  end

  // per-class result and state update
  always_comb begin
    streak_nxt   = streak_r;
    fail_cnt_nxt = fail_cnt_r;
    status_nxt   = 1'b0;
    rvalid_nxt   = 1'b0;
    temp_nxt     = '0;
    humid_nxt    = '0;
    fired_nxt    = 1'b0;
    unique case (d_cls_r)
      hsfc_pkg::CLS_HEAT: begin
        if (streak_r >= streak_need_r && d_wok_r) begin
          fired_nxt  = 1'b1;
          streak_nxt = '0;
        end
      end
      hsfc_pkg::CLS_BAD: begin
        status_nxt   = 1'b1;
        fail_cnt_nxt = fail_cnt_r + 1'b1;
      end
      hsfc_pkg::CLS_FRAME: begin
        rvalid_nxt = 1'b1;
        temp_nxt   = d_temp_r;
        humid_nxt  = d_humid_r;
        if (d_humid_r >= humid_trig_r) begin
          if (streak_r != hsfc_pkg::STREAK_MAX) begin
            streak_nxt = streak_r + 1'b1;
          end
        end else begin
          streak_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streak_r      <= '0;
      fail_cnt_r    <= '0;
      humid_trig_r  <= hsfc_pkg::HUMID_TRIGGER_RST;
      streak_need_r <= hsfc_pkg::STREAK_NEEDED_RST;
    end else begin
      if (d_adv) begin
        streak_r   <= streak_nxt;
        fail_cnt_r <= fail_cnt_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hsfc_pkg::CFG_HUMID_TRIGGER: humid_trig_r  <= cfg_data[HW-1:0];
          hsfc_pkg::CFG_STREAK_NEEDED: streak_need_r <= cfg_data[SW-1:0];
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (d_adv) begin
      status_r <= status_nxt;
      rvalid_r <= rvalid_nxt;
      temp_r   <= temp_nxt;
      humid_r  <= humid_nxt;
      fired_r  <= fired_nxt;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.status            = status_r;
  assign out_ch.reading_valid     = rvalid_r;
  assign out_ch.temperature_c100  = signed'(temp_r);
  assign out_ch.humidity_p100     = humid_r;
  assign out_ch.heater_fired      = fired_r;
  assign out_ch.streak_now        = streak_r;
  assign out_ch.crc_failure_total = fail_cnt_r;

`ifndef ASSERT_OFF
  // a fired heater leaves a cleared streak in the shown result
  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && fired_r) |-> (streak_r == '0))
    else $error("heater fired but streak not cleared");

  // a crc failure never carries a reading or a firing
  a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r) |-> (!rvalid_r && !fired_r && temp_r == '0 && humid_r == '0))
    else $error("crc failure result carries data");

  // failure count only steps by one, and only with a bad frame moving out
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(fail_cnt_r)) |->
      (fail_cnt_r == $past(fail_cnt_r) + 1'b1 && $past(d_adv)
       && $past(d_cls_r) == hsfc_pkg::CLS_BAD))
    else $error("crc failure count changed unexpectedly");

  // a shown reading is always within the clamp range
  a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && rvalid_r) |-> (humid_r <= HW'(hsfc_pkg::HUMID_MAX) && !status_r))
    else $error("reading out of range");
`endif

endmodule
